// ===== sv/e2q_pkg.sv =====
package e2q_pkg;

   localparam int ANGLE_BITS     = 16;
   localparam int QUAT_FRAC_BITS = 14;
   localparam int TRIG_STEPS     = 16;

   localparam int OUT_W   = QUAT_FRAC_BITS + 2;
   localparam int TRIG_W  = 32;
   localparam int VEC_W   = 33;
   localparam int ZACC_W  = 34;
   localparam int STEP_W  = (TRIG_STEPS > 1) ? $clog2(TRIG_STEPS) : 1;

   localparam logic signed [VEC_W-1:0] CORDIC_GAIN = 33'sd652032874;

   localparam logic [29:0] ATAN_TABLE [32] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
      30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
      30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
      30'd166886,    30'd83443,     30'd41722,     30'd20861,
      30'd10430,     30'd5215,      30'd2608,      30'd1304,
      30'd652,       30'd326,       30'd163,       30'd81,
      30'd41,        30'd20,        30'd10,        30'd5,
      30'd3,         30'd1,         30'd1,         30'd0
   };

   typedef struct packed {
      logic signed [ANGLE_BITS-1:0] roll_angle;
      logic signed [ANGLE_BITS-1:0] pitch_angle;
      logic signed [ANGLE_BITS-1:0] yaw_angle;
   } req_word_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] quat_w;
      logic signed [OUT_W-1:0] quat_x;
      logic signed [OUT_W-1:0] quat_y;
      logic signed [OUT_W-1:0] quat_z;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRIG,
      ST_MUL,
      ST_DRAIN,
      ST_OUT
   } e2q_state_type;

   typedef enum logic [1:0] {
      AXIS_ROLL,
      AXIS_PITCH,
      AXIS_YAW
   } e2q_axis_type;

   typedef enum logic [3:0] {
      MOP_CRCP,
      MOP_SRSP,
      MOP_SRCP,
      MOP_CRSP,
      MOP_W1,
      MOP_W2,
      MOP_X1,
      MOP_X2,
      MOP_Y1,
      MOP_Y2,
      MOP_Z1,
      MOP_Z2
   } e2q_mop_type;

endpackage

// ===== sv/e2q_cordic.sv =====
module e2q_cordic (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   trig_start,
   input  logic signed [e2q_pkg::ANGLE_BITS-1:0]  trig_angle,
   output logic                                   trig_done,
   output logic signed [e2q_pkg::TRIG_W-1:0]      trig_cos,
   output logic signed [e2q_pkg::TRIG_W-1:0]      trig_sin
);
   import e2q_pkg::*;

   logic signed [VEC_W-1:0]  x_ff, x_in;
   logic signed [VEC_W-1:0]  y_ff, y_in;
   logic signed [ZACC_W-1:0] z_ff, z_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic                     run_ff, run_in;
   logic                     done_ff, done_in;
   logic signed [VEC_W-1:0]  dx;
   logic signed [VEC_W-1:0]  dy;
   logic signed [ZACC_W-1:0] twice_atan;

   always_comb begin
      dx         = y_ff >>> step_ff;
      dy         = x_ff >>> step_ff;
      twice_atan = signed'(ZACC_W'({ATAN_TABLE[5'(step_ff)], 1'b0}));
      x_in       = x_ff;
      y_in       = y_ff;
      z_in       = z_ff;
      step_in    = step_ff;
      run_in     = run_ff;
      done_in    = 1'b0;
      if (trig_start) begin
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = ZACC_W'(trig_angle) <<< (32 - ANGLE_BITS);
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (!z_ff[ZACC_W-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - twice_atan;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + twice_atan;
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(TRIG_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
   end

   assign trig_done = done_ff;
   assign trig_cos  = x_ff[TRIG_W-1:0];
   assign trig_sin  = y_ff[TRIG_W-1:0];

endmodule

// ===== sv/e2q_mul.sv =====
module e2q_mul (
   input  logic                               clock,
   input  logic signed [e2q_pkg::TRIG_W-1:0]  mul_a,
   input  logic signed [e2q_pkg::TRIG_W-1:0]  mul_b,
   output logic signed [e2q_pkg::TRIG_W-1:0]  mul_rnd
);
   import e2q_pkg::*;

   logic signed [2*TRIG_W-1:0] prod_ff, prod_in;
   logic signed [2*TRIG_W-1:0] rnd_sum;

   always_comb begin
      prod_in = mul_a * mul_b;
      rnd_sum = prod_ff + (2*TRIG_W)'(64'sd1 <<< 29);
      mul_rnd = rnd_sum[61:30];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== sv/euler_to_quaternion.sv =====
// Channel   Ports                        Direction  Handshake
// request   start, busy, req_word        in         taken when start and not busy
// response  rsp_valid, rsp_word          out        one-cycle strobe, no back-pressure
//
// The shared CORDIC stage runs TRIG_STEPS rotations per angle, three angles in turn,
// then the shared multiplier issues twelve rounded products back to back.
// busy stays high from acceptance until the cycle the response is registered.
// Synchronous reset clears the sequencer and the strobe; no clearing pass.
// The receiver cannot stall: each response is shown for exactly one cycle.
module euler_to_quaternion (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  e2q_pkg::req_word_type  req_word,
   output logic                   rsp_valid,
   output e2q_pkg::rsp_word_type  rsp_word
);
   import e2q_pkg::*;

   localparam int RND_SH = 30 - QUAT_FRAC_BITS;
   localparam logic signed [TRIG_W+1:0] RND_HALF =
      (RND_SH > 0) ? ((TRIG_W+2)'(1) <<< (RND_SH - 1)) : '0;
   localparam logic signed [TRIG_W+1:0] ONE_Q = (TRIG_W+2)'(1) <<< QUAT_FRAC_BITS;

   e2q_state_type state_ff, state_in;
   e2q_axis_type  axis_ff, axis_in;
   e2q_mop_type   mop_ff, mop_in;
   e2q_mop_type   wr_op_ff;
   logic          wr_en_ff, wr_en_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_word_ff;
   logic          issue;

   logic signed [ANGLE_BITS-1:0] pitch_ff;
   logic signed [ANGLE_BITS-1:0] yaw_ff;

   logic                     trig_start;
   logic signed [ANGLE_BITS-1:0] trig_angle;
   logic                     trig_done;
   logic signed [TRIG_W-1:0] trig_cos;
   logic signed [TRIG_W-1:0] trig_sin;

   logic signed [TRIG_W-1:0] cr_ff, sr_ff, cp_ff, sp_ff, cy_ff, sy_ff;
   logic signed [TRIG_W-1:0] crcp_ff, srsp_ff, srcp_ff, crsp_ff;
   logic signed [TRIG_W-1:0] w1_ff, w2_ff, x1_ff, x2_ff, y1_ff, y2_ff, z1_ff, z2_ff;

   logic signed [TRIG_W-1:0] mul_a;
   logic signed [TRIG_W-1:0] mul_b;
   logic signed [TRIG_W-1:0] mul_rnd;

   function automatic logic signed [OUT_W-1:0] to_out(
      input logic signed [TRIG_W-1:0] a,
      input logic signed [TRIG_W-1:0] b,
      input logic                     neg
   );
      logic signed [TRIG_W+1:0] s;
      logic signed [TRIG_W+1:0] r;
      s = neg ? ((TRIG_W+2)'(a) - (TRIG_W+2)'(b)) : ((TRIG_W+2)'(a) + (TRIG_W+2)'(b));
      r = (s + RND_HALF) >>> RND_SH;
      if (r > ONE_Q) begin
         r = ONE_Q;
      end else if (r < -ONE_Q) begin
         r = -ONE_Q;
      end
      return r[OUT_W-1:0];
   endfunction

   e2q_cordic u_cordic (
      .clock      (clock),
      .reset      (reset),
      .trig_start (trig_start),
      .trig_angle (trig_angle),
      .trig_done  (trig_done),
      .trig_cos   (trig_cos),
      .trig_sin   (trig_sin)
   );

   e2q_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .mul_rnd (mul_rnd)
   );

   always_comb begin
      state_in   = state_ff;
      axis_in    = axis_ff;
      mop_in     = mop_ff;
      trig_start = 1'b0;
      trig_angle = req_word.roll_angle;
      issue      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               trig_start = 1'b1;
               axis_in    = AXIS_ROLL;
               state_in   = ST_TRIG;
            end
         end
         ST_TRIG: begin
            if (trig_done) begin
               unique case (axis_ff)
                  AXIS_ROLL: begin
                     trig_start = 1'b1;
                     trig_angle = pitch_ff;
                     axis_in    = AXIS_PITCH;
                  end
                  AXIS_PITCH: begin
                     trig_start = 1'b1;
                     trig_angle = yaw_ff;
                     axis_in    = AXIS_YAW;
                  end
                  AXIS_YAW: begin
                     mop_in   = MOP_CRCP;
                     state_in = ST_MUL;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MUL: begin
            issue = 1'b1;
            if (mop_ff == MOP_Z2) begin
               state_in = ST_DRAIN;
            end else begin
               mop_in = e2q_mop_type'(4'(mop_ff + 4'd1));
            end
         end
         ST_DRAIN: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      wr_en_in     = issue;
      rsp_valid_in = (state_ff == ST_OUT);
   end

   always_comb begin
      unique case (mop_ff)
         MOP_CRCP: begin mul_a = cr_ff;   mul_b = cp_ff; end
         MOP_SRSP: begin mul_a = sr_ff;   mul_b = sp_ff; end
         MOP_SRCP: begin mul_a = sr_ff;   mul_b = cp_ff; end
         MOP_CRSP: begin mul_a = cr_ff;   mul_b = sp_ff; end
         MOP_W1:   begin mul_a = crcp_ff; mul_b = cy_ff; end
         MOP_W2:   begin mul_a = srsp_ff; mul_b = sy_ff; end
         MOP_X1:   begin mul_a = srcp_ff; mul_b = cy_ff; end
         MOP_X2:   begin mul_a = crsp_ff; mul_b = sy_ff; end
         MOP_Y1:   begin mul_a = crsp_ff; mul_b = cy_ff; end
         MOP_Y2:   begin mul_a = srcp_ff; mul_b = sy_ff; end
         MOP_Z1:   begin mul_a = crcp_ff; mul_b = sy_ff; end
         MOP_Z2:   begin mul_a = srsp_ff; mul_b = cy_ff; end
         default:  begin mul_a = cr_ff;   mul_b = cp_ff; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= AXIS_ROLL;
         mop_ff       <= MOP_CRCP;
         wr_en_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         mop_ff       <= mop_in;
         wr_en_ff     <= wr_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_op_ff <= mop_ff;
      if (start && !busy) begin
         pitch_ff <= req_word.pitch_angle;
         yaw_ff   <= req_word.yaw_angle;
      end
      if (trig_done) begin
         case (axis_ff)
            AXIS_ROLL: begin
               cr_ff <= trig_cos;
               sr_ff <= trig_sin;
            end
            AXIS_PITCH: begin
               cp_ff <= trig_cos;
               sp_ff <= trig_sin;
            end
            default: begin
               cy_ff <= trig_cos;
               sy_ff <= trig_sin;
            end
         endcase
      end
      if (wr_en_ff) begin
         case (wr_op_ff)
            MOP_CRCP: crcp_ff <= mul_rnd;
            MOP_SRSP: srsp_ff <= mul_rnd;
            MOP_SRCP: srcp_ff <= mul_rnd;
            MOP_CRSP: crsp_ff <= mul_rnd;
            MOP_W1:   w1_ff   <= mul_rnd;
            MOP_W2:   w2_ff   <= mul_rnd;
            MOP_X1:   x1_ff   <= mul_rnd;
            MOP_X2:   x2_ff   <= mul_rnd;
            MOP_Y1:   y1_ff   <= mul_rnd;
            MOP_Y2:   y2_ff   <= mul_rnd;
            MOP_Z1:   z1_ff   <= mul_rnd;
            default:  z2_ff   <= mul_rnd;
         endcase
      end
      if (state_ff == ST_OUT) begin
         rsp_word_ff.quat_w <= to_out(w1_ff, w2_ff, 1'b0);
         rsp_word_ff.quat_x <= to_out(x1_ff, x2_ff, 1'b1);
         rsp_word_ff.quat_y <= to_out(y1_ff, y2_ff, 1'b0);
         rsp_word_ff.quat_z <= to_out(z1_ff, z2_ff, 1'b1);
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_rsp_after_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_OUT))
      else $error("response strobe without output stage");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_trig_in_trig: assert property (@(posedge clock) disable iff (reset)
      trig_done |-> (state_ff == ST_TRIG))
      else $error("trig result outside trig phase");

   a_write_in_mul: assert property (@(posedge clock) disable iff (reset)
      wr_en_ff |-> (state_ff == ST_MUL || state_ff == ST_DRAIN))
      else $error("product write outside multiply phase");

   a_rsp_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((TRIG_W+2)'(rsp_word.quat_w) <= ONE_Q
                  && (TRIG_W+2)'(rsp_word.quat_w) >= -ONE_Q))
      else $error("scalar part beyond unit range");

endmodule
